[hdl/ffh_pkg.sv]
package ffh_pkg;

    // One input word: a frame byte and its end-of-frame mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [63:0] flow_hash;
        logic [1:0]  status;
    } t_out_word;

    // FNV-1 64-bit basis and prime.
    localparam logic [63:0] HASH_SEED    = 64'hcbf2_9ce4_8422_2325;
    localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01b3;
    // Prime squared mod 2^64, sparse (15 set bits).
    localparam logic [63:0] FNV_PRIME_SQ = FNV_PRIME * FNV_PRIME;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_IPV4 = 2'd1;
    localparam logic [1:0] ST_NOT_L4   = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    // Header fields and offsets, relative to the start of the IPv4 header.
    localparam logic [3:0] IPV4_VERSION = 4'd4;
    localparam logic [3:0] IHL_MIN      = 4'd5;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [7:0] PROTO_UDP    = 8'd17;
    localparam logic [6:0] OFS_PROTO    = 7'd9;
    localparam logic [6:0] OFS_ADDR_LO  = 7'd12;
    localparam logic [6:0] OFS_ADDR_HI  = 7'd19;
    localparam logic [6:0] PORT_SPAN    = 7'd3;

    // Byte position saturates here.
    localparam logic [6:0] POS_MAX = 7'd127;

endpackage

[hdl/ffh_stream_if.sv]
interface ffh_stream_if #(
    parameter type t_word = logic
);
    logic  valid;
    logic  ready;
    t_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[hdl/ipv4_five_tuple_flow_hash_unit.sv]
// Channel | Dir | Payload                      | Words
// i_in    | in  | data_byte[7:0], last_byte    | one per frame byte
// o_out   | out | flow_hash[63:0], status[1:0] | one per frame, on the last byte
//
// Takes one word per cycle, sustained; the hash update is a constant multiply
// (two, summed, on the last address byte) between the input register and the
// state registers.
// A result word is presented from the result register, which is loaded when
// its last byte leaves the input register.
// Only a last-byte word can wait, and only while the result register is full
// and not taken; other words never stall.
// Reset is synchronous, active low; it loads the FNV basis and clears all
// control state.
module ipv4_five_tuple_flow_hash_unit #(
    parameter int L2_HEADER_BYTES = 14
) (
    input logic          i_clk,
    input logic          i_rst_n,
    ffh_stream_if.sink   i_in,
    ffh_stream_if.source o_out
);
    import ffh_pkg::*;

    // Positions of interest in the frame.
    localparam logic [6:0] P_BASE  = 7'(L2_HEADER_BYTES);
    localparam logic [6:0] P_PROTO = P_BASE + OFS_PROTO;
    localparam logic [6:0] P_ADDR0 = P_BASE + OFS_ADDR_LO;
    localparam logic [6:0] P_ADDR7 = P_BASE + OFS_ADDR_HI;

    // Input register.
    logic       r_iv;
    logic [7:0] r_ib;
    logic       r_il;

    // Frame state.
    logic [6:0]  r_pos;
    logic [63:0] r_hash;
    logic [7:0]  r_prot;
    logic [3:0]  r_hw;
    logic [1:0]  r_err;

    // Result register.
    logic      r_ov;
    t_out_word r_out;

    logic [6:0]  n_pos;
    logic [63:0] n_hash;
    logic [7:0]  n_prot;
    logic [3:0]  n_hw;
    logic [1:0]  n_err;
    logic [1:0]  n_status;
    logic [6:0]  n_port_lo;
    logic [6:0]  n_port_hi;

    logic        w_fire;
    logic        w_out_free;
    logic [63:0] w_prod;
    logic [63:0] w_mix1;
    logic [63:0] w_mix2;
    logic [8:0]  w_delta;
    logic [63:0] w_delta_ext;
    logic [63:0] w_delta_prod;

    // Handshake: a last-byte word needs a free result slot.
    assign w_out_free = !r_ov || o_out.ready;
    assign w_fire     = r_iv && (!r_il || w_out_free);
    assign i_in.ready = !r_iv || w_fire;

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

    // Single FNV-1 step: h*P ^ byte.
    assign w_prod = r_hash * FNV_PRIME;
    assign w_mix1 = w_prod ^ {56'd0, r_ib};

    // Two chained steps (last address byte, then protocol) folded into one update.
    // XOR with a byte only touches the low byte, so (h*P ^ b) = h*P + delta,
    // hence (h*P ^ b)*P = h*P^2 + delta*P. The protocol XOR is again low byte.
    assign w_delta      = {1'b0, w_prod[7:0] ^ r_ib} - {1'b0, w_prod[7:0]};
    assign w_delta_ext  = {{55{w_delta[8]}}, w_delta};
    assign w_delta_prod = w_delta_ext * FNV_PRIME;
    assign w_mix2       = ((r_hash * FNV_PRIME_SQ) + w_delta_prod) ^ {56'd0, r_prot};

    always_comb begin
        n_hw   = r_hw;
        n_prot = r_prot;
        n_err  = r_err;
        n_hash = r_hash;

        // Header checks; the first error found sticks.
        if (r_err == ST_OK) begin
            if (r_pos == P_BASE) begin
                n_hw = r_ib[3:0];
                if (r_ib[7:4] != IPV4_VERSION || r_ib[3:0] < IHL_MIN) begin
                    n_err = ST_NOT_IPV4;
                end
            end else if (r_pos == P_PROTO) begin
                n_prot = r_ib;
                if (r_ib != PROTO_TCP && r_ib != PROTO_UDP) begin
                    n_err = ST_NOT_L4;
                end
            end
        end

        // Transport header starts at 4*IHL.
        n_port_lo = P_BASE + {1'b0, n_hw, 2'b00};
        n_port_hi = n_port_lo + PORT_SPAN;

        if (n_err == ST_OK && r_pos > P_BASE) begin
            if (r_pos >= P_ADDR0 && r_pos <= P_ADDR7) begin
                n_hash = (r_pos == P_ADDR7) ? w_mix2 : w_mix1;
            end else if (r_pos >= n_port_lo && r_pos <= n_port_hi) begin
                n_hash = w_mix1;
            end
        end

        // End-of-frame status: short if the last port byte was not reached.
        n_status = n_err;
        if (n_err == ST_OK && (n_hw < IHL_MIN || r_pos < n_port_hi)) begin
            n_status = ST_SHORT;
        end

        n_pos = (r_pos < POS_MAX) ? r_pos + 7'd1 : r_pos;
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ib <= i_in.payload.data_byte;
            r_il <= i_in.payload.last_byte;
        end
    end

    // Control and frame state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_ov   <= 1'b0;
            r_pos  <= 7'd0;
            r_hash <= HASH_SEED;
            r_prot <= 8'd0;
            r_hw   <= 4'd0;
            r_err  <= ST_OK;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_iv <= 1'b1;
            end else if (w_fire) begin
                r_iv <= 1'b0;
            end

            if (w_fire && r_il) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            if (w_fire) begin
                if (r_il) begin
                    // Frame done: back to the idle frame state.
                    r_pos  <= 7'd0;
                    r_hash <= HASH_SEED;
                    r_prot <= 8'd0;
                    r_hw   <= 4'd0;
                    r_err  <= ST_OK;
                end else begin
                    r_pos  <= n_pos;
                    r_hash <= n_hash;
                    r_prot <= n_prot;
                    r_hw   <= n_hw;
                    r_err  <= n_err;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_fire && r_il) begin
            r_out.flow_hash <= (n_status == ST_OK) ? n_hash : 64'd0;
            r_out.status    <= n_status;
        end
    end

    // Nonzero status always carries a zero hash.
    a_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.status == ST_OK || r_out.flow_hash == 64'd0))
        else $error("flow hash nonzero with error status");

    // End of frame returns the frame state to its start.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_il |=> r_pos == 7'd0 && r_err == ST_OK && r_hash == HASH_SEED)
        else $error("frame state not restarted after last byte");

    // An error, once found, holds until the frame ends.
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !r_il && r_err != ST_OK |=> r_err == $past(r_err))
        else $error("error code changed mid-frame");

    // A held input word is not overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iv && !w_fire |=> r_iv && $stable(r_ib) && $stable(r_il))
        else $error("input word lost while waiting");

    // Position only advances within a frame.
    a_pos_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !r_il |=> r_pos >= $past(r_pos))
        else $error("byte position went backward");

endmodule

[dv/ipv4_five_tuple_flow_hash_unit_tb.sv]
module ipv4_five_tuple_flow_hash_unit_tb;
    import ffh_pkg::*;

    localparam int L2_BYTES    = 14;
    localparam int RAND_BYTES  = 700;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 25;    // results seen before the long receiver hold
    localparam int PRINT_CAP   = 40;

    // Byte fill used for a directed frame outside the version and protocol bytes.
    localparam logic [1:0] FILL_ZERO = 2'd0;
    localparam logic [1:0] FILL_ONES = 2'd1;
    localparam logic [1:0] FILL_RAND = 2'd2;

    // One directed frame. fixed=1: result typed in here (hash 0, given status);
    // fixed=0: result comes from the flow predictor.
    typedef struct packed {
        logic [7:0] len;
        logic [7:0] ver_ihl;
        logic [7:0] proto;
        logic [1:0] fill;
        logic       fixed;
        logic [1:0] status;
    } t_frame_row;

    // One queued input word plus what goes with it.
    typedef struct {
        t_in_word  w;
        bit        drain_first;     // hold this word back until nothing is outstanding
        bit        has_fixed;
        t_out_word fixed_res;
    } t_stim_word;

    localparam t_frame_row DIR_ROWS [22] = '{
        // len    ver/ihl  proto      fill       fixed status
        '{8'd1,   8'h45, PROTO_TCP, FILL_RAND, 1'b1, ST_SHORT},    // single byte frame
        '{8'd14,  8'h45, PROTO_TCP, FILL_RAND, 1'b1, ST_SHORT},    // ends before version
        '{8'd15,  8'h45, PROTO_TCP, FILL_ZERO, 1'b1, ST_SHORT},    // ends on version
        '{8'd24,  8'h45, PROTO_TCP, FILL_RAND, 1'b1, ST_SHORT},    // ends on protocol
        '{8'd37,  8'h45, PROTO_UDP, FILL_ONES, 1'b1, ST_SHORT},    // one byte short of ports
        '{8'd38,  8'h45, PROTO_TCP, FILL_ZERO, 1'b0, ST_OK},
        '{8'd38,  8'h45, PROTO_UDP, FILL_ONES, 1'b0, ST_OK},
        '{8'd60,  8'h45, PROTO_TCP, FILL_RAND, 1'b0, ST_OK},
        '{8'd77,  8'h4f, PROTO_UDP, FILL_RAND, 1'b1, ST_SHORT},    // max IHL, one short
        '{8'd78,  8'h4f, PROTO_TCP, FILL_ONES, 1'b0, ST_OK},       // max IHL
        '{8'd200, 8'h46, PROTO_UDP, FILL_RAND, 1'b0, ST_OK},       // position saturates
        '{8'd70,  8'h4a, PROTO_UDP, FILL_RAND, 1'b0, ST_OK},       // options present
        '{8'd50,  8'h47, PROTO_TCP, FILL_RAND, 1'b0, ST_OK},
        '{8'd60,  8'h65, PROTO_TCP, FILL_RAND, 1'b1, ST_NOT_IPV4}, // version 6
        '{8'd60,  8'h44, PROTO_TCP, FILL_RAND, 1'b1, ST_NOT_IPV4}, // IHL 4
        '{8'd60,  8'h40, PROTO_UDP, FILL_ZERO, 1'b1, ST_NOT_IPV4}, // IHL 0
        '{8'd60,  8'hff, PROTO_TCP, FILL_ONES, 1'b1, ST_NOT_IPV4},
        '{8'd15,  8'h35, PROTO_TCP, FILL_RAND, 1'b1, ST_NOT_IPV4}, // bad version on last byte
        '{8'd60,  8'h55, 8'h01,     FILL_RAND, 1'b1, ST_NOT_IPV4}, // version error wins
        '{8'd60,  8'h45, 8'h00,     FILL_ZERO, 1'b1, ST_NOT_L4},
        '{8'd24,  8'h45, 8'hff,     FILL_ONES, 1'b1, ST_NOT_L4},   // bad protocol on last byte
        '{8'd40,  8'h45, 8'h07,     FILL_RAND, 1'b1, ST_NOT_L4}
    };

    logic i_clk;
    logic i_rst_n;

    ffh_stream_if #(.t_word(t_in_word))  in_if ();
    ffh_stream_if #(.t_word(t_out_word)) out_if ();

    ipv4_five_tuple_flow_hash_unit #(
        .L2_HEADER_BYTES(L2_BYTES)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_stim_word  frame_words [$];
    t_out_word   hash_expect [$];

    // Flow predictor state.
    int          pos_q;
    logic [63:0] hash_q;
    logic [7:0]  proto_q;
    int          ihl_q;
    logic [1:0]  err_q;

    int          mismatches;
    int          results_seen;
    int          bytes_accepted;
    int          frames_queued;
    int          status_seen [4];
    int          cycles;
    int          hold_cycles_done;

    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          held;
    int          pat_mode;
    int          pat_left;
    t_stim_word  head;

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] prod;
        prod = h * FNV_PRIME;
        return prod ^ {56'd0, b};
    endfunction

    task automatic flow_state_clear();
        pos_q   = 0;
        hash_q  = HASH_SEED;
        proto_q = '0;
        ihl_q   = 0;
        err_q   = ST_OK;
    endtask

    // Advance the predictor by one accepted word; on the last byte queue the expected result.
    task automatic predict_word(input t_stim_word e);
        int          p;
        int          ports_lo;
        logic [7:0]  b;
        t_out_word   r;
        b = e.w.data_byte;
        p = pos_q;
        if (err_q == ST_OK) begin
            if (p == L2_BYTES) begin
                ihl_q = int'(b[3:0]);
                if (b[7:4] != IPV4_VERSION || b[3:0] < IHL_MIN) begin
                    err_q = ST_NOT_IPV4;
                end
            end else if (p == L2_BYTES + int'(OFS_PROTO)) begin
                proto_q = b;
                if (b != PROTO_TCP && b != PROTO_UDP) begin
                    err_q = ST_NOT_L4;
                end
            end
        end
        ports_lo = L2_BYTES + 4 * ihl_q;
        if (err_q == ST_OK && p > L2_BYTES) begin
            if (p >= L2_BYTES + int'(OFS_ADDR_LO) && p <= L2_BYTES + int'(OFS_ADDR_HI)) begin
                hash_q = fnv_mix(hash_q, b);
                // protocol byte folds in right after the last address byte
                if (p == L2_BYTES + int'(OFS_ADDR_HI)) begin
                    hash_q = fnv_mix(hash_q, proto_q);
                end
            end else if (p >= ports_lo && p <= ports_lo + int'(PORT_SPAN)) begin
                hash_q = fnv_mix(hash_q, b);
            end
        end
        if (pos_q < int'(POS_MAX)) begin
            pos_q++;
        end
        if (e.w.last_byte) begin
            r.status = err_q;
            if (err_q == ST_OK && (ihl_q < int'(IHL_MIN) || p < ports_lo + int'(PORT_SPAN))) begin
                r.status = ST_SHORT;
            end
            r.flow_hash = (r.status == ST_OK) ? hash_q : 64'd0;
            hash_expect.push_back(e.has_fixed ? e.fixed_res : r);
            flow_state_clear();
        end
    endtask

    task automatic add_frame(input int len, input logic [7:0] ver_ihl, input logic [7:0] proto,
                             input logic [1:0] fill, input bit fixed, input logic [1:0] st,
                             input bit drain);
        t_stim_word e;
        for (int p = 0; p < len; p++) begin
            e.drain_first = drain && (p == 0);
            e.w.last_byte = (p == len - 1);
            if (p == L2_BYTES) begin
                e.w.data_byte = ver_ihl;
            end else if (p == L2_BYTES + int'(OFS_PROTO)) begin
                e.w.data_byte = proto;
            end else begin
                case (fill)
                    FILL_ZERO: e.w.data_byte = 8'h00;
                    FILL_ONES: e.w.data_byte = 8'hff;
                    default:   e.w.data_byte = 8'($urandom);
                endcase
            end
            e.has_fixed           = fixed && (p == len - 1);
            e.fixed_res.status    = st;
            e.fixed_res.flow_hash = 64'd0;
            frame_words.push_back(e);
        end
        frames_queued++;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP) begin
            $display("MISMATCH result %0d %s: got %h want %h", results_seen, what, got, want);
        end
        mismatches++;
    endtask

    // Sender: bursts of random length with random gaps; the predictor runs on every
    // accepted word, so expectations are queued in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            flow_state_clear();
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                head = frame_words.pop_front();
                predict_word(head);
                bytes_accepted++;
            end
            if (in_if.valid && !in_if.ready) begin
                // stalled word stays on the bus
            end else if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (frame_words.size() == 0 ||
                         (frame_words[0].drain_first && hash_expect.size() != 0)) begin
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid   <= 1'b1;
                in_if.payload <= frame_words[0].w;
                frame_words[0].drain_first = 1'b0;
                burst_left--;
                if (burst_left <= 0) begin
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1, 2:    gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 30);
                    endcase
                    burst_left = $urandom_range(1, 48);
                end
            end
        end
    end

    // Receiver and checker: a stall pattern that changes mode after a random run,
    // plus one long hold-off so the result register fills and the input backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
            held      = 1'b0;
            pat_left  = 0;
            pat_mode  = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (hash_expect.size() == 0) begin
                    report_mismatch("unexpected word", out_if.payload.flow_hash, 64'd0);
                end else begin
                    head.fixed_res = hash_expect.pop_front();
                    if (out_if.payload.flow_hash !== head.fixed_res.flow_hash) begin
                        report_mismatch("flow_hash", out_if.payload.flow_hash,
                                        head.fixed_res.flow_hash);
                    end
                    if (out_if.payload.status !== head.fixed_res.status) begin
                        report_mismatch("status", 64'(out_if.payload.status),
                                        64'(head.fixed_res.status));
                    end
                    status_seen[head.fixed_res.status]++;
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                hold_cycles_done++;
                out_if.ready <= 1'b0;
            end else if (!held && results_seen >= HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                if (pat_left == 0) begin
                    pat_mode = $urandom_range(0, 3);
                    pat_left = $urandom_range(16, 96);
                end
                pat_left--;
                case (pat_mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= ((pat_left % 8) < 5);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycles, hash_expect.size());
            $display("ipv4_five_tuple_flow_hash_unit verification failed");
            $finish;
        end
    end

    initial begin
        int          rand_bytes;
        int          kind;
        int          ihl;
        int          need;
        int          len;
        bit          drain;
        bit          mid_done;
        logic [7:0]  vi;
        logic [7:0]  pr;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        out_if.ready  = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        bytes_accepted = 0;
        frames_queued = 0;
        cycles        = 0;
        hold_cycles_done = 0;
        for (int s = 0; s < 4; s++) begin
            status_seen[s] = 0;
        end

        // Directed frames.
        foreach (DIR_ROWS[i]) begin
            add_frame(int'(DIR_ROWS[i].len), DIR_ROWS[i].ver_ihl, DIR_ROWS[i].proto,
                      DIR_ROWS[i].fill, DIR_ROWS[i].fixed, DIR_ROWS[i].status, 1'b0);
        end

        // Random frames: mostly well-formed with random content, the rest truncated,
        // bad header fields, or noise. The first random frame, and one midway, wait
        // for every outstanding result before going out.
        rand_bytes = 0;
        mid_done   = 1'b0;
        drain      = 1'b1;
        while (rand_bytes < RAND_BYTES) begin
            kind = $urandom_range(0, 9);
            ihl  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
            vi   = {IPV4_VERSION, 4'(ihl)};
            pr   = $urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP;
            need = L2_BYTES + 4 * ihl + 4;
            if (kind < 7) begin
                len = need + $urandom_range(0, 12);
                if ($urandom_range(0, 19) == 0) begin
                    len = need + $urandom_range(13, 130);
                end
                if (len > 200) begin
                    len = 200;
                end
            end else if (kind == 7) begin
                len = $urandom_range(1, need - 1);
            end else if (kind == 8) begin
                if ($urandom_range(0, 1)) begin
                    vi = {IPV4_VERSION, 4'($urandom_range(0, 4))};
                end else begin
                    pr = 8'($urandom);
                end
                len = need + $urandom_range(0, 8);
            end else begin
                vi  = 8'($urandom);
                pr  = $urandom_range(0, 1) ? 8'($urandom) : pr;
                len = $urandom_range(1, 80);
            end
            if (!mid_done && rand_bytes >= RAND_BYTES / 2) begin
                drain    = 1'b1;
                mid_done = 1'b1;
            end
            add_frame(len, vi, pr, FILL_RAND, 1'b0, ST_OK, drain);
            drain = 1'b0;
            rand_bytes += len;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (frame_words.size() != 0 || in_if.valid) begin
            @(posedge i_clk);
        end
        while (hash_expect.size() != 0) begin
            @(posedge i_clk);
        end
        // wait on to catch any stray result word
        repeat (8) @(posedge i_clk);

        $display("ran %0d frames, %0d bytes, %0d results in %0d cycles",
                 frames_queued, bytes_accepted, results_seen, cycles);
        $display("status mix ok/not-ipv4/not-l4/short: %0d/%0d/%0d/%0d, hold-off %0d cycles",
                 status_seen[ST_OK], status_seen[ST_NOT_IPV4], status_seen[ST_NOT_L4],
                 status_seen[ST_SHORT], hold_cycles_done);
        if (mismatches == 0) begin
            $display("ipv4_five_tuple_flow_hash_unit verification clean");
        end else begin
            $display("ipv4_five_tuple_flow_hash_unit verification failed");
        end
        $finish;
    end

endmodule
